@@ rtl/laa_pkg.sv @@
// Package for the linear arena allocator: command, status and configuration index codes.
package laa_pkg;

  localparam logic [2:0] CmdAlloc   = 3'd0;
  localparam logic [2:0] CmdDealloc = 3'd1;
  localparam logic [2:0] CmdReset   = 3'd2;
  localparam logic [2:0] CmdMark    = 3'd3;
  localparam logic [2:0] CmdRestore = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StInvalid  = 3'd1;
  localparam logic [2:0] StNoRecord = 3'd2;
  localparam logic [2:0] StGenExh   = 3'd3;
  localparam logic [2:0] StCapacity = 3'd4;

  localparam logic [1:0] CfgCapacity = 2'd0;
  localparam logic [1:0] CfgMaxAlign = 2'd1;
  localparam logic [1:0] CfgTag      = 2'd2;

endpackage

@@ rtl/linear_arena_allocator_unit.sv @@
// Bump-pointer arena allocator with a record table held in synchronous memory.
//
// Usage: pulse start_i with a command and its request fields while busy_o is
// low. The block raises busy_o and, when the command is done, shows one
// result for exactly one cycle with done_o high. The receiver cannot stall.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and are meant for idle periods only.
//
// Mark, reset and failed argument checks finish in the read state right
// after accept. Allocate, deallocate and restore walk the record table with
// a read state and an evaluate state per record (issue the read, then
// evaluate the registered read data); allocate ends with a commit state.
// Allocate stops at the first free record, deallocate at the first match,
// and restore, once its checks pass, sweeps the whole table. Every command
// then passes the done state; a new one is accepted only once the block is
// idle again.
//
// Record valid bits are flip-flops cleared at reset, so there is no clearing
// pass; the record fields themselves have no reset. After reset the counters
// hold their reset values and the arena generation and block generation
// are one.
module linear_arena_allocator_unit #(
  parameter int RECORD_COUNT = 64,
  parameter int OFFSET_BITS  = 32,
  parameter int GEN_BITS     = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [2:0]             command_i,
  input  logic [31:0]            req_size_i,
  input  logic [16:0]            req_alignment_i,
  input  logic [3:0]             req_tag_i,
  input  logic [31:0]            req_offset_i,
  input  logic [31:0]            req_generation_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i,
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic [31:0]            block_offset_o,
  output logic [31:0]            block_generation_o,
  output logic [31:0]            used_bytes_out_o,
  output logic [31:0]            peak_bytes_out_o,
  output logic [31:0]            waste_bytes_out_o,
  output logic [6:0]             active_out_o,
  output logic [31:0]            alloc_count_out_o,
  output logic [31:0]            fail_count_out_o,
  output logic [31:0]            arena_generation_out_o
);

  localparam int IdxW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
  localparam int CntW = $clog2(RECORD_COUNT + 1);
  localparam int OW   = OFFSET_BITS;
  localparam int GW   = GEN_BITS;
  // wide enough for 32-bit fields and the offset width
  localparam int WW   = (OW > 32) ? OW + 1 : 33;
  localparam int RecW = OW + OW + 32 + 17 + 4 + GW;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1; // issue read of record idx
  localparam logic [2:0] SEval = 3'd2; // read data valid
  localparam logic [2:0] SDone = 3'd3;
  localparam logic [2:0] SAloc = 3'd4; // capacity check and commit

  typedef struct packed {
    logic [OW-1:0] rstart;
    logic [OW-1:0] rend;
    logic [31:0]   rsize;
    logic [16:0]   ralign;
    logic [3:0]    rtag;
    logic [GW-1:0] rgen;
  } rec_t;

  logic [2:0]  state_q, state_d;
  logic [31:0] cap_q;
  logic [16:0] maxal_q;
  logic [3:0]  atag_q;

  logic [2:0]  cmd_q;
  logic [31:0] size_q;
  logic [16:0] align_q;
  logic [3:0]  tag_q;
  logic [31:0] roff_q;
  logic [31:0] rgen_q;

  logic [RECORD_COUNT-1:0] valid_q;
  logic [IdxW-1:0]         idx_q;
  logic [OW-1:0]           used_q, peak_q;
  logic [31:0]             waste_q, allocs_q, fails_q;
  logic [CntW-1:0]         active_q;
  logic [GW-1:0]           agen_q, bgen_q;

  logic [2:0]  st_q;
  logic [31:0] boff_q, bgo_q;
  logic        done_q;

  // record memory
  logic [RecW-1:0] mem_q [RECORD_COUNT];
  rec_t            rd_q;
  logic            we;
  logic [IdxW-1:0] waddr;
  rec_t            wdat;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdat;
    end
    rd_q <= rec_t'(mem_q[idx_q]);
  end

  // widened views of the operands
  logic [WW-1:0] used_w, align_w, size_w, cap_w, aligned_w, offmask_w, roff_w;
  logic [WW-1:0] cap_eff_w, padw_w;
  logic          is_last, rmatch;
  logic          arg_bad;

  always_comb begin
    offmask_w = WW'({OW{1'b1}});
    used_w    = WW'(used_q);
    align_w   = WW'(align_q);
    size_w    = WW'(size_q);
    roff_w    = WW'(roff_q);
    cap_w     = WW'(cap_q);
    cap_eff_w = (cap_w > offmask_w) ? offmask_w : cap_w;
    aligned_w = (used_w + align_w - WW'(1)) & ~(align_w - WW'(1));
    padw_w    = aligned_w - used_w;
    is_last   = (idx_q == IdxW'(RECORD_COUNT - 1));
    rmatch    = valid_q[idx_q] && rd_q.rstart == OW'(roff_q) &&
                WW'(rd_q.rgen) == WW'(rgen_q) && rd_q.rsize == size_q &&
                rd_q.ralign == align_q && rd_q.rtag == tag_q;
    arg_bad   = size_q == 32'd0 || align_q == 17'd0 ||
                (align_q & (align_q - 17'd1)) != 17'd0 ||
                align_q > maxal_q || tag_q != atag_q;
  end

  logic [2:0] fin_st;
  logic       fin;

  always_comb begin
    state_d = state_q;
    fin     = 1'b0;
    fin_st  = laa_pkg::StOk;
    we      = 1'b0;
    waddr   = idx_q;
    wdat.rstart = OW'(aligned_w);
    wdat.rend   = OW'(aligned_w + size_w);
    wdat.rsize  = size_q;
    wdat.ralign = align_q;
    wdat.rtag   = tag_q;
    wdat.rgen   = bgen_q;
    unique case (state_q)
      SIdle: if (start_i) state_d = SRead;
      SRead: begin
        state_d = SEval;
        unique case (cmd_q)
          laa_pkg::CmdAlloc: begin
            if (arg_bad) begin
              fin = 1'b1; fin_st = laa_pkg::StInvalid;
            end else if (&valid_q) begin
              fin = 1'b1; fin_st = laa_pkg::StNoRecord;
            end else if (bgen_q == {GW{1'b1}}) begin
              fin = 1'b1; fin_st = laa_pkg::StGenExh;
            end
          end
          laa_pkg::CmdDealloc: ;
          laa_pkg::CmdRestore: begin
            if (WW'(rgen_q) != WW'(agen_q) || roff_w > used_w) begin
              fin = 1'b1; fin_st = laa_pkg::StInvalid;
            end
          end
          laa_pkg::CmdReset, laa_pkg::CmdMark: fin = 1'b1;
          default: begin
            fin = 1'b1; fin_st = laa_pkg::StInvalid;
          end
        endcase
        if (fin) state_d = SDone;
      end
      SEval: begin
        state_d = SRead;
        unique case (cmd_q)
          laa_pkg::CmdAlloc: if (!valid_q[idx_q]) state_d = SAloc;
          laa_pkg::CmdDealloc: begin
            if (rmatch) begin
              fin = 1'b1;
            end else if (is_last) begin
              fin = 1'b1; fin_st = laa_pkg::StInvalid;
            end
          end
          default: if (is_last) fin = 1'b1; // restore sweep
        endcase
        if (fin) state_d = SDone;
      end
      SAloc: begin
        fin = 1'b1;
        if (used_w > offmask_w - (align_w - WW'(1)) || aligned_w > cap_eff_w ||
            size_w > cap_eff_w - aligned_w) begin
          fin_st = laa_pkg::StCapacity;
        end else begin
          we = 1'b1;
        end
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      cap_q    <= 32'd65536;
      maxal_q  <= 17'd16;
      atag_q   <= 4'd0;
      valid_q  <= '0;
      idx_q    <= '0;
      used_q   <= '0;
      peak_q   <= '0;
      waste_q  <= '0;
      allocs_q <= '0;
      fails_q  <= '0;
      active_q <= '0;
      agen_q   <= GW'(1);
      bgen_q   <= GW'(1);
      done_q   <= 1'b0;
      st_q     <= laa_pkg::StOk;
      boff_q   <= '0;
      bgo_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          laa_pkg::CfgCapacity: cap_q   <= cfg_data_i;
          laa_pkg::CfgMaxAlign: maxal_q <= cfg_data_i[16:0];
          laa_pkg::CfgTag:      atag_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (state_q == SIdle && start_i) begin
        idx_q  <= '0;
        boff_q <= '0;
        bgo_q  <= '0;
      end
      if (state_q == SEval && state_d == SRead) idx_q <= idx_q + IdxW'(1);
      // restore sweep frees records that end past the marker
      if (state_q == SEval && cmd_q == laa_pkg::CmdRestore &&
          valid_q[idx_q] && WW'(rd_q.rend) > roff_w) begin
        valid_q[idx_q] <= 1'b0;
        active_q       <= active_q - CntW'(1);
      end
      if (state_q == SEval && cmd_q == laa_pkg::CmdDealloc && rmatch) begin
        valid_q[idx_q] <= 1'b0;
        active_q       <= active_q - CntW'(1);
      end
      if (state_q == SEval && cmd_q == laa_pkg::CmdRestore && is_last) begin
        used_q <= OW'(roff_q);
      end
      if (state_q == SRead && cmd_q == laa_pkg::CmdReset) begin
        valid_q  <= '0;
        used_q   <= '0;
        waste_q  <= '0;
        active_q <= '0;
        agen_q   <= agen_q + GW'(1);
      end
      if (we) begin
        valid_q[idx_q] <= 1'b1;
        boff_q   <= 32'(aligned_w);
        bgo_q    <= 32'(bgen_q);
        bgen_q   <= bgen_q + GW'(1);
        waste_q  <= (padw_w > WW'(32'hFFFF_FFFF) ||
                     WW'(waste_q) > WW'(32'hFFFF_FFFF) - padw_w) ?
                    32'hFFFF_FFFF : waste_q + 32'(padw_w);
        used_q   <= OW'(aligned_w + size_w);
        if (OW'(aligned_w + size_w) > peak_q) peak_q <= OW'(aligned_w + size_w);
        active_q <= active_q + CntW'(1);
        allocs_q <= allocs_q + 32'd1;
      end
      if (fin) begin
        st_q   <= fin_st;
        done_q <= 1'b1;
        if (fin_st != laa_pkg::StOk) fails_q <= fails_q + 32'd1;
      end
    end
  end

  // command capture, payload only
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) begin
      cmd_q   <= command_i;
      size_q  <= req_size_i;
      align_q <= req_alignment_i;
      tag_q   <= req_tag_i;
      roff_q  <= req_offset_i;
      rgen_q  <= req_generation_i;
    end
  end

  assign busy_o                 = state_q != SIdle;
  assign done_o                 = done_q;
  assign status_o               = st_q;
  assign block_offset_o         = boff_q;
  assign block_generation_o     = bgo_q;
  assign used_bytes_out_o       = 32'(used_q);
  assign peak_bytes_out_o       = 32'(peak_q);
  assign waste_bytes_out_o      = waste_q;
  assign active_out_o           = 7'(active_q);
  assign alloc_count_out_o      = allocs_q;
  assign fail_count_out_o       = fails_q;
  assign arena_generation_out_o = 32'(agen_q);

endmodule
